/* design/gba_pkg.sv */
// Shared types, codes and defaults for the grouped bitmap allocator.
package gba_pkg;

    // Field and register widths
    localparam int NUM_W       = 17;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int GC_CFG_W    = 4;
    localparam int BYTES_CFG_W = 11;

    // Parameter defaults
    localparam int MAX_GROUPS_DEF      = 8;
    localparam int MAX_GROUP_BYTES_DEF = 1024;
    localparam int WORD_BITS_DEF       = 64;

    // Register reset values
    localparam logic [GC_CFG_W-1:0]    GROUP_COUNT_RST = 4'd1;
    localparam logic [BYTES_CFG_W-1:0] BLOCK_BYTES_RST = 11'd1024;
    localparam logic [BYTES_CFG_W-1:0] INODE_BYTES_RST = 11'd256;

    // Opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Pools
    localparam logic POOL_BLOCK = 1'b0;
    localparam logic POOL_INODE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INODE_BYTES = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ASCAN,
        ST_FDIV,
        ST_FMOD
    } t_state;

endpackage

/* design/gba_ram.sv */
// Generic single-port RAM with registered read data.
module gba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/gba_find.sv */
// First clear bit finder; the most significant bit is position zero.
module gba_find #(
    parameter int WORD_BITS = 64
) (
    input  logic [WORD_BITS-1:0]         i_word,
    output logic                         o_found,
    output logic [$clog2(WORD_BITS)-1:0] o_pos
);

    // Later iterations win, so the highest clear bit is reported
    always_comb begin
        o_found = 1'b0;
        o_pos   = '0;
        for (int k = 0; k < WORD_BITS; k++) begin
            if (!i_word[k]) begin
                o_found = 1'b1;
                o_pos   = $clog2(WORD_BITS)'(WORD_BITS - 1 - k);
            end
        end
    end

endmodule

/* design/grouped_bitmap_allocator.sv */
// Allocate: issue reads the first word, then one bitmap word per scan step, then the strobe.
// Free: steps over groups while dividing, then a read and a write, then the strobe.
// One transaction at a time through a single-port bitmap RAM; busy covers accepted operations.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) restores the control and configuration registers and
// then clears every RAM word with busy high.
module grouped_bitmap_allocator #(
    parameter int MAX_GROUPS      = gba_pkg::MAX_GROUPS_DEF,
    parameter int MAX_GROUP_BYTES = gba_pkg::MAX_GROUP_BYTES_DEF,
    parameter int WORD_BITS       = gba_pkg::WORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_opcode,
    input  logic                            i_pool,
    input  logic [gba_pkg::NUM_W-1:0]       i_item_number,
    output logic                            o_result_valid,
    output logic [gba_pkg::NUM_W-1:0]       o_granted_number,
    output logic [gba_pkg::STATUS_W-1:0]    o_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gba_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gba_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SLOT_BITS  = MAX_GROUP_BYTES * 8;
    localparam int SLOT_WORDS = SLOT_BITS / WORD_BITS;
    localparam int POOL_WORDS = MAX_GROUPS * SLOT_WORDS;
    localparam int DEPTH      = 2 * POOL_WORDS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int G_W        = $clog2(MAX_GROUPS + 1);
    localparam int W_W        = $clog2(SLOT_WORDS + 1);
    localparam int ENT_W      = $clog2(SLOT_BITS + 1);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int NUM_W      = gba_pkg::NUM_W;

    // Registers
    gba_pkg::t_state                    r_state, n_state;
    logic                               r_pool, n_pool;
    logic [G_W-1:0]                     r_g, n_g;
    logic [W_W-1:0]                     r_w, n_w;
    logic [NUM_W-1:0]                   r_rem, n_rem;
    logic [ADDR_W-1:0]                  r_clr, n_clr;
    logic                               r_out_valid, n_out_valid;
    logic [NUM_W-1:0]                   r_granted, n_granted;
    logic [gba_pkg::STATUS_W-1:0]       r_status, n_status;
    logic [gba_pkg::GC_CFG_W-1:0]       r_group_count;
    logic [gba_pkg::BYTES_CFG_W-1:0]    r_block_bytes;
    logic [gba_pkg::BYTES_CFG_W-1:0]    r_inode_bytes;

    // RAM port
    logic                               mem_we;
    logic [ADDR_W-1:0]                  mem_addr;
    logic [WORD_BITS-1:0]               mem_wdata;
    logic [WORD_BITS-1:0]               mem_rdata;

    // Effective geometry
    logic [G_W-1:0]                     eff_groups;
    logic [ENT_W-1:0]                   eff_ents_start;
    logic [ENT_W-1:0]                   eff_ents;
    logic [gba_pkg::BYTES_CFG_W-1:0]    bytes_start;
    logic [gba_pkg::BYTES_CFG_W-1:0]    bytes_cur;

    // Scan signals
    logic [31:0]                        w_base;
    logic [31:0]                        w_lim;
    logic [WORD_BITS-1:0]               valid_mask;
    logic [WORD_BITS-1:0]               scan_word;
    logic                               hit;
    logic [BIT_W-1:0]                   hit_pos;
    logic                               more_w;
    logic                               more_g;
    logic                               geo_empty;
    logic                               free_bad_num;
    logic                               rem_ge;
    logic                               last_g;
    logic [BIT_W-1:0]                   free_pos;

    function automatic logic [ADDR_W-1:0] word_addr(input logic pool, input logic [G_W-1:0] g,
                                                     input logic [31:0] w);
        word_addr = ADDR_W'(32'(pool) * POOL_WORDS + 32'(g) * SLOT_WORDS + w);
    endfunction

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_count <= gba_pkg::GROUP_COUNT_RST;
            r_block_bytes <= gba_pkg::BLOCK_BYTES_RST;
            r_inode_bytes <= gba_pkg::INODE_BYTES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                gba_pkg::CFG_GROUP_COUNT: r_group_count <= i_cfg_data[gba_pkg::GC_CFG_W-1:0];
                gba_pkg::CFG_BLOCK_BYTES: r_block_bytes <= i_cfg_data;
                gba_pkg::CFG_INODE_BYTES: r_inode_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Saturated geometry for the incoming pool and the pool in work
    assign eff_groups = (32'(r_group_count) > MAX_GROUPS) ? G_W'(MAX_GROUPS)
                                                          : G_W'(r_group_count);
    assign bytes_start = (i_pool == gba_pkg::POOL_INODE) ? r_inode_bytes : r_block_bytes;
    assign bytes_cur   = (r_pool == gba_pkg::POOL_INODE) ? r_inode_bytes : r_block_bytes;
    assign eff_ents_start = (32'(bytes_start) > MAX_GROUP_BYTES) ? ENT_W'(SLOT_BITS)
                                                                 : ENT_W'(32'(bytes_start) * 8);
    assign eff_ents = (32'(bytes_cur) > MAX_GROUP_BYTES) ? ENT_W'(SLOT_BITS)
                                                         : ENT_W'(32'(bytes_cur) * 8);
    assign geo_empty    = (eff_groups == '0) || (eff_ents_start == '0);
    assign free_bad_num = (i_pool == gba_pkg::POOL_INODE) && (i_item_number == '0);

    // Word check during an allocate scan: bits past the group end count as used
    assign w_base = 32'(r_w) * WORD_BITS;
    assign w_lim  = 32'(eff_ents) - w_base;

    always_comb begin
        for (int k = 0; k < WORD_BITS; k++) begin
            valid_mask[k] = (32'(WORD_BITS - 1 - k) < w_lim);
        end
    end

    assign scan_word = mem_rdata | ~valid_mask;

    gba_find #(
        .WORD_BITS (WORD_BITS)
    ) u_find (
        .i_word  (scan_word),
        .o_found (hit),
        .o_pos   (hit_pos)
    );

    assign more_w = (w_base + 32'(WORD_BITS)) < 32'(eff_ents);
    assign more_g = (32'(r_g) + 32'd1) < 32'(eff_groups);

    // Free: group found by repeated subtraction
    assign rem_ge   = 32'(r_rem) >= 32'(eff_ents);
    assign last_g   = (32'(r_g) + 32'd1) >= 32'(eff_groups);
    assign free_pos = BIT_W'(r_rem % WORD_BITS);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gba_pkg::ST_CLEAR: begin
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = gba_pkg::ST_IDLE;
                end
            end
            gba_pkg::ST_IDLE: begin
                if (start) begin
                    if (geo_empty || (i_opcode == gba_pkg::OP_FREE && free_bad_num)) begin
                        n_state = gba_pkg::ST_IDLE;
                    end else if (i_opcode == gba_pkg::OP_ALLOC) begin
                        n_state = gba_pkg::ST_ASCAN;
                    end else begin
                        n_state = gba_pkg::ST_FDIV;
                    end
                end
            end
            gba_pkg::ST_ASCAN: begin
                if (hit || (!more_w && !more_g)) begin
                    n_state = gba_pkg::ST_IDLE;
                end
            end
            gba_pkg::ST_FDIV: begin
                if (rem_ge && last_g) begin
                    n_state = gba_pkg::ST_IDLE;
                end else if (!rem_ge) begin
                    n_state = gba_pkg::ST_FMOD;
                end
            end
            gba_pkg::ST_FMOD: begin
                n_state = gba_pkg::ST_IDLE;
            end
            default: n_state = gba_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_pool      = r_pool;
        n_g         = r_g;
        n_w         = r_w;
        n_rem       = r_rem;
        n_clr       = r_clr;
        n_out_valid = 1'b0;
        n_granted   = r_granted;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_addr    = word_addr(r_pool, r_g, 32'(r_w));
        mem_wdata   = '0;
        unique case (r_state)
            gba_pkg::ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                n_clr    = r_clr + ADDR_W'(1);
            end
            gba_pkg::ST_IDLE: begin
                if (start) begin
                    n_pool = i_pool;
                    n_g    = '0;
                    n_w    = '0;
                    n_rem  = (i_pool == gba_pkg::POOL_INODE) ? i_item_number - NUM_W'(1)
                                                             : i_item_number;
                    mem_addr = word_addr(i_pool, '0, 32'd0);
                    if (geo_empty || (i_opcode == gba_pkg::OP_FREE && free_bad_num)) begin
                        n_out_valid = 1'b1;
                        n_granted   = '0;
                        n_status    = (i_opcode == gba_pkg::OP_ALLOC) ? gba_pkg::STAT_FULL
                                                                      : gba_pkg::STAT_RANGE;
                    end
                end
            end
            gba_pkg::ST_ASCAN: begin
                if (hit) begin
                    mem_we      = 1'b1;
                    mem_wdata   = mem_rdata | (WORD_BITS'(1) << (BIT_W'(WORD_BITS - 1) - hit_pos));
                    n_out_valid = 1'b1;
                    n_status    = gba_pkg::STAT_DONE;
                    n_granted   = NUM_W'(32'(r_pool) + 32'(r_g) * 32'(eff_ents) + w_base
                                         + 32'(hit_pos));
                end else if (more_w) begin
                    n_w      = r_w + W_W'(1);
                    mem_addr = word_addr(r_pool, r_g, 32'(r_w) + 32'd1);
                end else if (more_g) begin
                    n_g      = r_g + G_W'(1);
                    n_w      = '0;
                    mem_addr = word_addr(r_pool, r_g + G_W'(1), 32'd0);
                end else begin
                    n_out_valid = 1'b1;
                    n_granted   = '0;
                    n_status    = gba_pkg::STAT_FULL;
                end
            end
            gba_pkg::ST_FDIV: begin
                if (rem_ge) begin
                    if (last_g) begin
                        n_out_valid = 1'b1;
                        n_granted   = '0;
                        n_status    = gba_pkg::STAT_RANGE;
                    end else begin
                        n_rem = r_rem - NUM_W'(eff_ents);
                        n_g   = r_g + G_W'(1);
                    end
                end else begin
                    n_w      = W_W'(r_rem / WORD_BITS);
                    mem_addr = word_addr(r_pool, r_g, 32'(r_rem / WORD_BITS));
                end
            end
            gba_pkg::ST_FMOD: begin
                mem_we      = 1'b1;
                mem_wdata   = mem_rdata & ~(WORD_BITS'(1) << (BIT_W'(WORD_BITS - 1) - free_pos));
                n_out_valid = 1'b1;
                n_granted   = '0;
                n_status    = gba_pkg::STAT_DONE;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gba_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pool    <= n_pool;
        r_g       <= n_g;
        r_w       <= n_w;
        r_rem     <= n_rem;
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    gba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign busy             = (r_state != gba_pkg::ST_IDLE);
    assign o_result_valid   = r_out_valid;
    assign o_granted_number = r_granted;
    assign o_status         = r_status;

`ifndef SYNTHESIS
    // A result only follows a cycle of work or a start request
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy) || $past(start))
        else $error("result without a transaction");

    // Failures carry no number
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != gba_pkg::STAT_DONE) |-> (o_granted_number == '0))
        else $error("failed transaction carries a number");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_status == gba_pkg::STAT_DONE || o_status == gba_pkg::STAT_FULL
                            || o_status == gba_pkg::STAT_RANGE))
        else $error("undefined status code");
`endif

endmodule
